FILE: rtl/rrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_pkg: shared definitions for the region remap table
// Operation codes, field widths and the header size helper.
// ----------------------------------------------------------------------------
package rrt_pkg;

   // Operation codes carried on the request tuser
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam int unsigned OP_W    = 2;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned REQ_DATA_W = 4 * VALUE_W;
   // Result tdata carries a byte of zero fill above the index and offset.
   localparam int unsigned RSP_PAD_W  = 8;
   localparam int unsigned RSP_DATA_W = INDEX_W + VALUE_W + RSP_PAD_W;
   localparam int unsigned RSP_USER_W = 2;

   typedef logic [VALUE_W-1:0] value_type;

   // Header size: 8 bytes per entry plus one, rounded up to 16 bytes.
   function automatic value_type header_size(input value_type count);
      value_type raw;
      raw = (count + value_type'(1)) << 3;
      return (raw + value_type'(15)) & ~value_type'(15);
   endfunction

endpackage

FILE: rtl/rrt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data appears in the cycle
// after the address.
// ----------------------------------------------------------------------------
module rrt_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 256,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/region_remap_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_remap_table: table of redirected regions with ordered lookup
// Clear, append and lookup words on a stream; one result word per request.
// ----------------------------------------------------------------------------
// Regions live in one RAM (start and size side by side), loaded in order and
// capped at TABLE_DEPTH entries. A lookup walks the loaded entries from index
// zero through the single RAM read port, one entry per cycle, and stops at the
// first region that overlaps [position, position + length). Clear, append and
// unused codes and a lookup on an empty table skip the walk and go straight
// to the result. One request is in work at a time; a new request is taken
// while the previous result still waits in the output register.
module region_remap_table #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   // Request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: region_offset[31:0], region_size[63:32], read_position[95:64],
   //        read_length[127:96]
   input  logic [rrt_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: operation[1:0]
   input  logic [rrt_pkg::OP_W-1:0]       req_tuser,
   // Response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: entry_index[7:0], remapped_offset[39:8], zero fill[47:40]
   output logic [rrt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: hit[0], table_full[1]
   output logic [rrt_pkg::RSP_USER_W-1:0] rsp_tuser
);

   import rrt_pkg::*;

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // Request fields
   logic [OP_W-1:0] req_op;
   value_type       req_offset;
   value_type       req_size;
   value_type       req_pos;
   value_type       req_len;
   logic            req_fire;

   assign req_op     = req_tuser;
   assign req_offset = req_tdata[VALUE_W-1:0];
   assign req_size   = req_tdata[2*VALUE_W-1:VALUE_W];
   assign req_pos    = req_tdata[3*VALUE_W-1:2*VALUE_W];
   assign req_len    = req_tdata[4*VALUE_W-1:3*VALUE_W];
   assign req_fire   = req_tvalid && req_tready;

   // Control state
   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          chk_valid_ff, chk_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [AW-1:0]  chk_idx_ff, chk_idx_in;
   value_type      pos_ff, pos_in;
   logic [VALUE_W:0] read_end_ff, read_end_in;
   value_type      running_ff, running_in;
   logic           res_hit_ff, res_hit_in;
   logic [INDEX_W-1:0] res_idx_ff, res_idx_in;
   value_type      res_offset_ff, res_offset_in;
   logic           res_full_ff, res_full_in;
   logic           out_hit_ff, out_hit_in;
   logic [INDEX_W-1:0] out_idx_ff, out_idx_in;
   value_type      out_offset_ff, out_offset_in;
   logic           out_full_ff, out_full_in;

   // RAM signals
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [2*VALUE_W-1:0] ram_wr_data;
   logic [2*VALUE_W-1:0] ram_rd_data;
   value_type         ent_start;
   value_type         ent_size;

   assign ent_start = ram_rd_data[VALUE_W-1:0];
   assign ent_size  = ram_rd_data[2*VALUE_W-1:VALUE_W];

   rrt_ram #(
      .WIDTH (2 * VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Overlap test on the entry read back, without 32-bit wrap
   logic [VALUE_W:0] region_end;
   logic             overlap;
   logic             last_entry;
   logic             out_free;

   assign region_end = {1'b0, ent_start} + {1'b0, ent_size};
   assign overlap    = ({1'b0, pos_ff} < region_end) && (read_end_ff > {1'b0, ent_start});
   assign last_entry = (CW'(chk_idx_ff) + CW'(1)) == count_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Appends write at the current count while the table has room
   assign ram_wr_en   = req_fire && (req_op == OP_APPEND) && (count_ff != FULL_COUNT);
   assign ram_wr_addr = count_ff[AW-1:0];
   assign ram_wr_data = {req_size, req_offset};

   // Sequencer: request decode, table walk, result hand-off
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = issue_ff[AW-1:0];
      pos_in        = pos_ff;
      read_end_in   = read_end_ff;
      running_in    = running_ff;
      res_hit_in    = res_hit_ff;
      res_idx_in    = res_idx_ff;
      res_offset_in = res_offset_ff;
      res_full_in   = res_full_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_hit_in    = 1'b0;
               res_idx_in    = '0;
               res_offset_in = '0;
               res_full_in   = 1'b0;
               state_in      = ST_EMIT;
               unique case (req_op)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff != FULL_COUNT) begin
                        count_in = count_ff + CW'(1);
                     end else begin
                        res_full_in = 1'b1;
                     end
                  end
                  OP_LOOKUP: begin
                     pos_in      = req_pos;
                     read_end_in = {1'b0, req_pos} + {1'b0, req_len};
                     running_in  = header_size(VALUE_W'(count_ff));
                     issue_in    = '0;
                     if (count_ff != '0) begin
                        state_in = ST_WALK;
                     end
                  end
                  OP_NONE: begin
                     state_in = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // Issue the next read while the previous entry is checked
            if (issue_ff < count_ff) begin
               chk_valid_in = 1'b1;
               issue_in     = issue_ff + CW'(1);
            end
            if (chk_valid_ff) begin
               if (overlap) begin
                  res_hit_in    = 1'b1;
                  res_idx_in    = INDEX_W'(chk_idx_ff);
                  res_offset_in = running_ff + (pos_ff - ent_start);
                  chk_valid_in  = 1'b0;
                  state_in      = ST_EMIT;
               end else begin
                  running_in = running_ff + ent_size;
                  if (last_entry) begin
                     chk_valid_in = 1'b0;
                     state_in     = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_hit_in    = out_hit_ff;
      out_idx_in    = out_idx_ff;
      out_offset_in = out_offset_ff;
      out_full_in   = out_full_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_EMIT) && out_free) begin
         rsp_valid_in  = 1'b1;
         out_hit_in    = res_hit_ff;
         out_idx_in    = res_idx_ff;
         out_offset_in = res_offset_ff;
         out_full_in   = res_full_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      pos_ff        <= pos_in;
      read_end_ff   <= read_end_in;
      running_ff    <= running_in;
      res_hit_ff    <= res_hit_in;
      res_idx_ff    <= res_idx_in;
      res_offset_ff <= res_offset_in;
      res_full_ff   <= res_full_in;
      out_hit_ff    <= out_hit_in;
      out_idx_ff    <= out_idx_in;
      out_offset_ff <= out_offset_in;
      out_full_ff   <= out_full_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_offset_ff, out_idx_ff};
   assign rsp_tuser  = {out_full_ff, out_hit_ff};

`ifndef SYNTHESIS
   // The entry count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count exceeds table depth");

   // An entry under check always lies below the entry count.
   a_check_in_range: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (CW'(chk_idx_ff) < count_ff))
      else $error("walk checks an entry beyond the count");

   // A clear empties the table on the next cycle.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_CLEAR)) |=> (count_ff == '0))
      else $error("clear did not reset the entry count");

   // A result word never reports both a hit and a dropped append.
   a_hit_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_hit_ff && out_full_ff))
      else $error("hit and table full reported together");

   // Walk checks only happen while the walk is running.
   a_check_in_walk: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (state_ff == ST_WALK))
      else $error("entry check outside the walk");
`endif

endmodule
